// ===== rtl/core/ftmtc_pkg.sv =====
`timescale 1ns / 1ps

package ftmtc_pkg;

    localparam int ADDR_W   = 48;
    localparam int TOKEN_W  = 8;
    localparam int TIME_W   = 48;
    localparam int REQ_W    = 3;
    localparam int FKIND_W  = 2;
    localparam int RKIND_W  = 4;
    localparam int CNT_W    = 2;

    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = REQ_W + FKIND_W;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = RKIND_W;

    localparam logic [REQ_W-1:0] REQ_TX      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RX      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OPEN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLOSE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd5;

    localparam logic [FKIND_W-1:0] FK_OTHER    = 2'd0;
    localparam logic [FKIND_W-1:0] FK_FTM_RESP = 2'd1;
    localparam logic [FKIND_W-1:0] FK_ACK      = 2'd2;

    localparam logic [RKIND_W-1:0] RK_NONE       = 4'd0;
    localparam logic [RKIND_W-1:0] RK_T1         = 4'd1;
    localparam logic [RKIND_W-1:0] RK_T2         = 4'd2;
    localparam logic [RKIND_W-1:0] RK_T3         = 4'd3;
    localparam logic [RKIND_W-1:0] RK_T4         = 4'd4;
    localparam logic [RKIND_W-1:0] RK_OPENED     = 4'd5;
    localparam logic [RKIND_W-1:0] RK_EXISTED    = 4'd6;
    localparam logic [RKIND_W-1:0] RK_REFUSED    = 4'd7;
    localparam logic [RKIND_W-1:0] RK_CLOSED     = 4'd8;
    localparam logic [RKIND_W-1:0] RK_CLOSE_MISS = 4'd9;
    localparam logic [RKIND_W-1:0] RK_BLOCKED    = 4'd10;
    localparam logic [RKIND_W-1:0] RK_UNBLOCKED  = 4'd11;
    localparam logic [RKIND_W-1:0] RK_FULL       = 4'd12;

    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FKIND_W-1:0] frame_kind;
        logic [ADDR_W-1:0]  receiver_address;
        logic [ADDR_W-1:0]  transmitter_address;
        logic [TOKEN_W-1:0] frame_token;
        logic [TIME_W-1:0]  event_time;
        logic [ADDR_W-1:0]  partner_address;
    } item_t;

    typedef struct packed {
        logic [RKIND_W-1:0] result_kind;
        logic [ADDR_W-1:0]  peer_address;
        logic [TOKEN_W-1:0] token_out;
        logic [TIME_W-1:0]  stamp_ps;
    } result_t;

endpackage

// ===== rtl/core/ftmtc_in_stage.sv =====
`timescale 1ns / 1ps

module ftmtc_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // receiver_address, transmitter_address, frame_token, event_time, partner_address
    input  logic [ftmtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type, frame_kind
    input  logic [ftmtc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              advance,
    output logic                              item_valid,
    output ftmtc_pkg::item_t                  item
);
    import ftmtc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready = aresetn && (!valid_reg || advance);

    always_comb begin
        item_next                     = item_reg;
        valid_next                    = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next                    = 1'b1;
            item_next.req_type            = s_tuser[REQ_W-1:0];
            item_next.frame_kind          = s_tuser[REQ_W +: FKIND_W];
            item_next.receiver_address    = s_tdata[47:0];
            item_next.transmitter_address = s_tdata[95:48];
            item_next.frame_token         = s_tdata[103:96];
            item_next.event_time          = s_tdata[151:104];
            item_next.partner_address     = s_tdata[199:152];
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/ftmtc_core.sv =====
`timescale 1ns / 1ps

module ftmtc_core #(
    parameter int SESSION_SLOTS = 8,
    parameter int BLOCK_SLOTS   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ftmtc_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic                          advance,
    input  ftmtc_pkg::item_t              item,
    output ftmtc_pkg::result_t            result
);
    import ftmtc_pkg::*;

    logic [ADDR_W-1:0]  own_reg;

    logic [SESSION_SLOTS-1:0] sess_used_reg;
    logic [SESSION_SLOTS-1:0] sess_used_next;
    logic [ADDR_W-1:0]        sess_partner [SESSION_SLOTS];
    logic [BLOCK_SLOTS-1:0]   blk_used_reg;
    logic [BLOCK_SLOTS-1:0]   blk_used_next;
    logic [ADDR_W-1:0]        blk_partner [BLOCK_SLOTS];

    logic               awaiting_ack_reg, awaiting_ack_next;
    logic               sending_ack_reg, sending_ack_next;
    logic [CNT_W-1:0]   rx_since_tx_reg, rx_since_tx_next;
    logic [CNT_W-1:0]   tx_since_rx_reg, tx_since_rx_next;
    logic [ADDR_W-1:0]  tx_peer_reg, tx_peer_next;
    logic [TOKEN_W-1:0] tx_token_reg, tx_token_next;
    logic [ADDR_W-1:0]  rx_peer_reg, rx_peer_next;
    logic [TOKEN_W-1:0] rx_token_reg, rx_token_next;
    logic [ADDR_W-1:0]  ack_target_reg, ack_target_next;

    logic [ADDR_W-1:0]        key;
    logic [SESSION_SLOTS-1:0] sess_match;
    logic [SESSION_SLOTS-1:0] sess_first_match;
    logic [SESSION_SLOTS-1:0] sess_free_first;
    logic [BLOCK_SLOTS-1:0]   blk_match;
    logic [BLOCK_SLOTS-1:0]   blk_free_first;
    logic                     sess_hit;
    logic                     blk_hit;
    logic [SESSION_SLOTS-1:0] sess_wr;
    logic [BLOCK_SLOTS-1:0]   blk_wr;
    logic [CNT_W-1:0]         tx_bumped;
    logic [CNT_W-1:0]         rx_bumped;
    result_t                  res;

    // session lookup key depends on the request
    always_comb begin
        key = item.partner_address;
        case (item.req_type)
            REQ_TX: begin
                key = (item.frame_kind == FK_ACK) ? rx_peer_reg : item.receiver_address;
            end
            REQ_RX: begin
                key = (item.frame_kind == FK_ACK) ? tx_peer_reg : item.transmitter_address;
            end
            default: key = item.partner_address;
        endcase
    end

    always_comb begin
        for (int i = 0; i < SESSION_SLOTS; i++) begin
            sess_match[i] = sess_used_reg[i] && (sess_partner[i] == key);
        end
        for (int j = 0; j < BLOCK_SLOTS; j++) begin
            blk_match[j] = blk_used_reg[j] && (blk_partner[j] == item.partner_address);
        end
    end

    assign sess_hit         = |sess_match;
    assign blk_hit          = |blk_match;
    assign sess_first_match = sess_match & (~sess_match + 1'b1);
    assign sess_free_first  = ~sess_used_reg & (sess_used_reg + 1'b1);
    assign blk_free_first   = ~blk_used_reg & (blk_used_reg + 1'b1);

    assign tx_bumped = (tx_since_rx_reg < CNT_SAT) ? tx_since_rx_reg + 1'b1 : CNT_SAT;
    assign rx_bumped = (rx_since_tx_reg < CNT_SAT) ? rx_since_tx_reg + 1'b1 : CNT_SAT;

    always_comb begin
        res                = '0;
        sess_used_next     = sess_used_reg;
        blk_used_next      = blk_used_reg;
        sess_wr            = '0;
        blk_wr             = '0;
        awaiting_ack_next  = awaiting_ack_reg;
        sending_ack_next   = sending_ack_reg;
        rx_since_tx_next   = rx_since_tx_reg;
        tx_since_rx_next   = tx_since_rx_reg;
        tx_peer_next       = tx_peer_reg;
        tx_token_next      = tx_token_reg;
        rx_peer_next       = rx_peer_reg;
        rx_token_next      = rx_token_reg;
        ack_target_next    = ack_target_reg;
        res.result_kind    = RK_NONE;
        case (item.req_type)
            REQ_TX: begin
                tx_since_rx_next = tx_bumped;
                if (item.frame_kind == FK_FTM_RESP) begin
                    if (sess_hit) begin
                        res.result_kind   = RK_T1;
                        res.peer_address  = item.receiver_address;
                        res.token_out     = item.frame_token;
                        res.stamp_ps      = item.event_time;
                        rx_since_tx_next  = '0;
                        awaiting_ack_next = 1'b1;
                        tx_peer_next      = item.receiver_address;
                        tx_token_next     = item.frame_token;
                    end
                end else if (item.frame_kind == FK_ACK) begin
                    if (sending_ack_reg && tx_bumped == CNT_ONE
                            && ack_target_reg == item.receiver_address) begin
                        sending_ack_next = 1'b0;
                        if (sess_hit) begin
                            res.result_kind  = RK_T3;
                            res.peer_address = rx_peer_reg;
                            res.token_out    = rx_token_reg;
                            res.stamp_ps     = item.event_time;
                        end
                    end
                end
            end
            REQ_RX: begin
                rx_since_tx_next = rx_bumped;
                if (item.receiver_address == own_reg) begin
                    if (item.frame_kind == FK_FTM_RESP) begin
                        sending_ack_next = 1'b1;
                        tx_since_rx_next = '0;
                        ack_target_next  = item.transmitter_address;
                        if (sess_hit && item.frame_token != '0) begin
                            res.result_kind  = RK_T2;
                            res.peer_address = item.transmitter_address;
                            res.token_out    = item.frame_token;
                            res.stamp_ps     = item.event_time;
                            rx_peer_next     = item.transmitter_address;
                            rx_token_next    = item.frame_token;
                        end
                    end else if (item.frame_kind == FK_ACK && awaiting_ack_reg) begin
                        awaiting_ack_next = 1'b0;
                        if (rx_bumped == CNT_ONE && sess_hit) begin
                            res.result_kind  = RK_T4;
                            res.peer_address = tx_peer_reg;
                            res.token_out    = tx_token_reg;
                            res.stamp_ps     = item.event_time;
                        end
                    end
                end
            end
            REQ_OPEN: begin
                res.peer_address = item.partner_address;
                if (sess_hit) begin
                    res.result_kind = RK_EXISTED;
                end else if (blk_hit || item.partner_address == own_reg) begin
                    res.result_kind = RK_REFUSED;
                end else if (|sess_free_first) begin
                    res.result_kind = RK_OPENED;
                    sess_wr         = sess_free_first;
                    sess_used_next  = sess_used_reg | sess_free_first;
                end else begin
                    res.result_kind = RK_FULL;
                end
            end
            REQ_CLOSE: begin
                res.peer_address = item.partner_address;
                if (sess_hit) begin
                    res.result_kind = RK_CLOSED;
                    sess_used_next  = sess_used_reg & ~sess_first_match;
                end else begin
                    res.result_kind = RK_CLOSE_MISS;
                end
            end
            REQ_BLOCK: begin
                res.peer_address = item.partner_address;
                if (blk_hit) begin
                    res.result_kind = RK_BLOCKED;
                end else if (|blk_free_first) begin
                    res.result_kind = RK_BLOCKED;
                    blk_wr          = blk_free_first;
                    blk_used_next   = blk_used_reg | blk_free_first;
                end else begin
                    res.result_kind = RK_FULL;
                end
            end
            REQ_UNBLOCK: begin
                res.peer_address = item.partner_address;
                res.result_kind  = RK_UNBLOCKED;
                blk_used_next    = blk_used_reg & ~blk_match;
            end
            default: res.result_kind = RK_NONE;
        endcase
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg          <= '0;
            sess_used_reg    <= '0;
            blk_used_reg     <= '0;
            awaiting_ack_reg <= 1'b0;
            sending_ack_reg  <= 1'b0;
            rx_since_tx_reg  <= '0;
            tx_since_rx_reg  <= '0;
            tx_peer_reg      <= '0;
            tx_token_reg     <= '0;
            rx_peer_reg      <= '0;
            rx_token_reg     <= '0;
            ack_target_reg   <= '0;
        end else begin
            if (cfg_we) begin
                own_reg <= cfg_addr;
            end
            if (advance) begin
                sess_used_reg    <= sess_used_next;
                blk_used_reg     <= blk_used_next;
                awaiting_ack_reg <= awaiting_ack_next;
                sending_ack_reg  <= sending_ack_next;
                rx_since_tx_reg  <= rx_since_tx_next;
                tx_since_rx_reg  <= tx_since_rx_next;
                tx_peer_reg      <= tx_peer_next;
                tx_token_reg     <= tx_token_next;
                rx_peer_reg      <= rx_peer_next;
                rx_token_reg     <= rx_token_next;
                ack_target_reg   <= ack_target_next;
            end
        end
    end

    // partner storage, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SESSION_SLOTS; i++) begin
            if (advance && sess_wr[i]) begin
                sess_partner[i] <= item.partner_address;
            end
        end
        for (int j = 0; j < BLOCK_SLOTS; j++) begin
            if (advance && blk_wr[j]) begin
                blk_partner[j] <= item.partner_address;
            end
        end
    end

endmodule

// ===== rtl/core/ftmtc_out_stage.sv =====
`timescale 1ns / 1ps

module ftmtc_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  ftmtc_pkg::result_t                result,
    output logic                              out_busy,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // peer_address, token_out, stamp_ps
    output logic [ftmtc_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind
    output logic [ftmtc_pkg::M_TUSER_W-1:0]   m_tuser
);
    import ftmtc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (advance) begin
            res_reg <= result;
        end
    end

    assign out_busy = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tdata  = {res_reg.stamp_ps, res_reg.token_out, res_reg.peer_address};

endmodule

// ===== rtl/core/ftm_timestamp_capture.sv =====
`timescale 1ns / 1ps

// 802.11 fine timing measurement timestamp capture. Every request (phy tx
// start, phy rx start, or a session open, close, block or unblock) produces
// exactly one result: T1..T4 with peer, dialog token and picosecond time, a
// table status, or none. Requests are taken one per cycle while results are
// taken as they come. Each request is registered in the input stage and its
// result in the output stage; a stalled output holds requests back. The core
// compares the address in parallel with all session and blocked slots and
// updates the tables before the next request is evaluated. No clearing pass
// is needed after reset. The user writes own_address over the cfg channel
// only while no request is in flight; the block does not enforce this.
module ftm_timestamp_capture #(
    parameter int SESSION_SLOTS = 8,
    parameter int BLOCK_SLOTS   = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ftmtc_pkg::ADDR_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // receiver_address, transmitter_address, frame_token, event_time, partner_address
    input  logic [ftmtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type, frame_kind
    input  logic [ftmtc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // peer_address, token_out, stamp_ps
    output logic [ftmtc_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind
    output logic [ftmtc_pkg::M_TUSER_W-1:0]   m_tuser
);
    import ftmtc_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    out_busy;
    logic    advance;

    assign cfg_ready = aresetn;
    assign advance   = item_valid && !out_busy;

    ftmtc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ftmtc_core #(
        .SESSION_SLOTS (SESSION_SLOTS),
        .BLOCK_SLOTS   (BLOCK_SLOTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_data),
        .advance  (advance),
        .item     (item),
        .result   (result)
    );

    ftmtc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_busy (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_ftm_timestamp_capture.sv =====
`timescale 1ns / 1ps

module tb_ftm_timestamp_capture;
    import ftmtc_pkg::*;

    localparam int N_SESS        = 8;
    localparam int N_BLOCK       = 8;
    localparam int POOL_SIZE     = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;

    // request and frame codes the block treats as no event / other frame
    localparam logic [REQ_W-1:0]   REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0]   REQ_SPARE_B = 3'd7;
    localparam logic [FKIND_W-1:0] FK_SPARE    = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // receiver_address, transmitter_address, frame_token, event_time, partner_address
    logic [S_TDATA_W-1:0] s_tdata;
    // req_type, frame_kind
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // peer_address, token_out, stamp_ps
    logic [M_TDATA_W-1:0] m_tdata;
    // result_kind
    logic [M_TUSER_W-1:0] m_tuser;

    ftm_timestamp_capture uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predicted block state
    logic [ADDR_W-1:0]  own_addr       = '0;
    logic               sess_used [N_SESS]  = '{default: 1'b0};
    logic [ADDR_W-1:0]  sess_peer [N_SESS]  = '{default: '0};
    logic               blk_used  [N_BLOCK] = '{default: 1'b0};
    logic [ADDR_W-1:0]  blk_peer  [N_BLOCK] = '{default: '0};
    logic               ack_expected   = 1'b0;
    logic               ack_owed       = 1'b0;
    logic [CNT_W-1:0]   rx_count       = '0;
    logic [CNT_W-1:0]   tx_count       = '0;
    logic [ADDR_W-1:0]  last_tx_peer   = '0;
    logic [TOKEN_W-1:0] last_tx_token  = '0;
    logic [ADDR_W-1:0]  last_rx_peer   = '0;
    logic [TOKEN_W-1:0] last_rx_token  = '0;
    logic [ADDR_W-1:0]  ack_dest       = '0;

    result_t           pending_captures [$];
    logic [ADDR_W-1:0] partner_pool [POOL_SIZE];
    int                error_count    = 0;
    int                sent_items     = 0;
    int                src_idle_pct   = 0;
    int                dst_stall_pct  = 0;
    int                hold_orders    = 0;
    int                holds_served   = 0;
    int                quiet_cycles   = 0;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [ADDR_W-1:0] rnd48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == CNT_SAT) ? CNT_SAT : c + CNT_ONE;
    endfunction

    function automatic int session_slot(logic [ADDR_W-1:0] a);
        for (int i = 0; i < N_SESS; i++)
            if (sess_used[i] && sess_peer[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int blocked_slot(logic [ADDR_W-1:0] a);
        for (int i = 0; i < N_BLOCK; i++)
            if (blk_used[i] && blk_peer[i] == a)
                return i;
        return -1;
    endfunction

    function automatic result_t capture_result(item_t it);
        result_t r;
        int      slot;
        r = '0;
        slot = -1;
        case (it.req_type)
            REQ_TX: begin
                tx_count = sat_inc(tx_count);
                if (it.frame_kind == FK_FTM_RESP) begin
                    if (session_slot(it.receiver_address) >= 0) begin
                        r = '{RK_T1, it.receiver_address, it.frame_token, it.event_time};
                        rx_count = '0;
                        ack_expected = 1'b1;
                        last_tx_peer = it.receiver_address;
                        last_tx_token = it.frame_token;
                    end
                end else if (it.frame_kind == FK_ACK) begin
                    if (ack_owed && tx_count == CNT_ONE && ack_dest == it.receiver_address) begin
                        ack_owed = 1'b0;
                        if (session_slot(last_rx_peer) >= 0)
                            r = '{RK_T3, last_rx_peer, last_rx_token, it.event_time};
                    end
                end
            end
            REQ_RX: begin
                rx_count = sat_inc(rx_count);
                if (it.receiver_address == own_addr) begin
                    if (it.frame_kind == FK_FTM_RESP) begin
                        ack_owed = 1'b1;
                        tx_count = '0;
                        ack_dest = it.transmitter_address;
                        if (session_slot(it.transmitter_address) >= 0 && it.frame_token != '0) begin
                            r = '{RK_T2, it.transmitter_address, it.frame_token, it.event_time};
                            last_rx_peer = it.transmitter_address;
                            last_rx_token = it.frame_token;
                        end
                    end else if (it.frame_kind == FK_ACK && ack_expected) begin
                        ack_expected = 1'b0;
                        if (rx_count == CNT_ONE && session_slot(last_tx_peer) >= 0)
                            r = '{RK_T4, last_tx_peer, last_tx_token, it.event_time};
                    end
                end
            end
            REQ_OPEN: begin
                r.peer_address = it.partner_address;
                if (session_slot(it.partner_address) >= 0) begin
                    r.result_kind = RK_EXISTED;
                end else if (blocked_slot(it.partner_address) >= 0 ||
                             it.partner_address == own_addr) begin
                    r.result_kind = RK_REFUSED;
                end else begin
                    for (int i = N_SESS - 1; i >= 0; i--)
                        if (!sess_used[i])
                            slot = i;
                    if (slot < 0) begin
                        r.result_kind = RK_FULL;
                    end else begin
                        sess_used[slot] = 1'b1;
                        sess_peer[slot] = it.partner_address;
                        r.result_kind = RK_OPENED;
                    end
                end
            end
            REQ_CLOSE: begin
                r.peer_address = it.partner_address;
                slot = session_slot(it.partner_address);
                if (slot >= 0) begin
                    sess_used[slot] = 1'b0;
                    r.result_kind = RK_CLOSED;
                end else begin
                    r.result_kind = RK_CLOSE_MISS;
                end
            end
            REQ_BLOCK: begin
                r.peer_address = it.partner_address;
                r.result_kind = RK_BLOCKED;
                if (blocked_slot(it.partner_address) < 0) begin
                    for (int i = N_BLOCK - 1; i >= 0; i--)
                        if (!blk_used[i])
                            slot = i;
                    if (slot < 0) begin
                        r.result_kind = RK_FULL;
                    end else begin
                        blk_used[slot] = 1'b1;
                        blk_peer[slot] = it.partner_address;
                    end
                end
            end
            REQ_UNBLOCK: begin
                r.peer_address = it.partner_address;
                r.result_kind = RK_UNBLOCKED;
                for (int i = 0; i < N_BLOCK; i++)
                    if (blk_used[i] && blk_peer[i] == it.partner_address)
                        blk_used[i] = 1'b0;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.req_type            = REQ_W'($urandom_range(7));
        it.frame_kind          = FKIND_W'($urandom_range(3));
        it.receiver_address    = rnd48();
        it.transmitter_address = rnd48();
        it.frame_token         = TOKEN_W'($urandom_range(255));
        it.event_time          = rnd48();
        it.partner_address     = rnd48();
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_partner();
        if ($urandom_range(11) == 0)
            return own_addr;
        return partner_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endfunction

    task automatic send_request(input item_t it);
        result_t r;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {it.partner_address, it.event_time, it.frame_token,
                     it.transmitter_address, it.receiver_address};
        s_tuser  <= {it.frame_kind, it.req_type};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = capture_result(it);
        pending_captures = {pending_captures, r};
        sent_items++;
    endtask

    task automatic send_table_op(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] pa);
        item_t it;
        it = noise_item();
        it.req_type = req;
        it.partner_address = pa;
        send_request(it);
    endtask

    task automatic send_frame(input logic [REQ_W-1:0] req, input logic [FKIND_W-1:0] kind,
                              input logic [ADDR_W-1:0] ra, input logic [ADDR_W-1:0] ta,
                              input logic [TOKEN_W-1:0] tok, input logic [TIME_W-1:0] t);
        item_t it;
        it = noise_item();
        it.req_type            = req;
        it.frame_kind          = kind;
        it.receiver_address    = ra;
        it.transmitter_address = ta;
        it.frame_token         = tok;
        it.event_time          = t;
        send_request(it);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_captures.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_own_address(input logic [ADDR_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        own_addr = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_sequence();
        logic [ADDR_W-1:0]  p;
        logic [TOKEN_W-1:0] tok;
        p = pick_partner();
        tok = ($urandom_range(7) == 0) ? '0 : TOKEN_W'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2: begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_table_op(REQ_OPEN, p);
                    4, 5:       send_table_op(REQ_CLOSE, p);
                    6, 7:       send_table_op(REQ_BLOCK, p);
                    default:    send_table_op(REQ_UNBLOCK, p);
                endcase
            end
            3, 4, 5: begin
                // we send the response, the peer acks it
                send_frame(REQ_TX, FK_FTM_RESP, p, rnd48(), tok, rnd48());
                if ($urandom_range(7) == 0)
                    send_request(noise_item());
                send_frame(REQ_RX, FK_ACK, own_addr, p, TOKEN_W'($urandom_range(255)),
                           rnd48());
            end
            6, 7: begin
                // the peer sends the response, we ack it
                send_frame(REQ_RX, FK_FTM_RESP, own_addr, p, tok, rnd48());
                if ($urandom_range(7) == 0)
                    send_request(noise_item());
                send_frame(REQ_TX, FK_ACK, p, rnd48(), TOKEN_W'($urandom_range(255)),
                           rnd48());
            end
            default: send_request(noise_item());
        endcase
    endtask

    task automatic test_directed();
        logic [ADDR_W-1:0] p0, p1, p2;
        p0 = partner_pool[2];
        p1 = partner_pool[3];
        p2 = partner_pool[4];
        settle();
        write_own_address(48'h0012_3456_789A);
        send_table_op(REQ_OPEN, p0);
        send_table_op(REQ_OPEN, p0);
        send_table_op(REQ_OPEN, own_addr);
        send_table_op(REQ_BLOCK, p1);
        send_table_op(REQ_BLOCK, p1);
        send_table_op(REQ_OPEN, p1);
        send_table_op(REQ_UNBLOCK, p1);
        send_table_op(REQ_UNBLOCK, p1);
        send_table_op(REQ_CLOSE, p2);
        send_frame(REQ_TX, FK_FTM_RESP, p0, rnd48(), 8'h5A, '1);
        send_frame(REQ_RX, FK_ACK, own_addr, p0, 8'h00, '0);
        send_frame(REQ_RX, FK_FTM_RESP, own_addr, p0, 8'hFF, rnd48());
        send_frame(REQ_TX, FK_ACK, p0, rnd48(), 8'h00, rnd48());
        // zero token: ack armed but no T2, latched token kept
        send_frame(REQ_RX, FK_FTM_RESP, own_addr, p0, 8'h00, rnd48());
        send_frame(REQ_TX, FK_ACK, p0, rnd48(), 8'h11, rnd48());
        send_frame(REQ_RX, FK_FTM_RESP, p1, p0, 8'h01, rnd48());
        // ack not first frame after our response
        send_frame(REQ_TX, FK_FTM_RESP, p0, rnd48(), 8'h3C, rnd48());
        send_frame(REQ_RX, FK_OTHER, own_addr, p0, 8'h00, rnd48());
        send_frame(REQ_RX, FK_ACK, own_addr, p0, 8'h00, rnd48());
        send_frame(REQ_RX, FK_ACK, own_addr, p0, 8'h00, rnd48());
        send_frame(REQ_TX, FK_FTM_RESP, p2, rnd48(), 8'h77, rnd48());
        send_frame(REQ_SPARE_A, FK_FTM_RESP, own_addr, p0, 8'h22, rnd48());
        send_frame(REQ_SPARE_B, FK_ACK, own_addr, p0, 8'h33, rnd48());
        send_frame(REQ_RX, FK_SPARE, own_addr, p0, 8'h44, rnd48());
        send_table_op(REQ_CLOSE, p0);
        settle();
    endtask

    task automatic test_phase(input logic [ADDR_W-1:0] own, input int src_pct,
                              input int dst_pct, input int target);
        int start;
        settle();
        write_own_address(own);
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        start = sent_items;
        while (sent_items - start < target)
            random_sequence();
        settle();
    endtask

    task automatic test_backpressure();
        settle();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        hold_orders++;
        repeat (20) random_sequence();
        settle();
        repeat (10) random_sequence();
        settle();
    endtask

    // receiver side
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_orders != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= dst_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.result_kind  = m_tuser;
            got.peer_address = m_tdata[ADDR_W-1:0];
            got.token_out    = m_tdata[ADDR_W +: TOKEN_W];
            got.stamp_ps     = m_tdata[ADDR_W + TOKEN_W +: TIME_W];
            if (pending_captures.size() == 0) begin
                note_mismatch("unexpected result_kind", '0, 64'(got.result_kind));
            end else begin
                want = pending_captures.pop_front();
                if (got.result_kind !== want.result_kind)
                    note_mismatch("result_kind", 64'(want.result_kind),
                                  64'(got.result_kind));
                if (got.peer_address !== want.peer_address)
                    note_mismatch("peer_address", 64'(want.peer_address),
                                  64'(got.peer_address));
                if (got.token_out !== want.token_out)
                    note_mismatch("token_out", 64'(want.token_out), 64'(got.token_out));
                if (got.stamp_ps !== want.stamp_ps)
                    note_mismatch("stamp_ps", 64'(want.stamp_ps), 64'(got.stamp_ps));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        partner_pool[0] = '0;
        partner_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            partner_pool[i] = rnd48();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_phase('0, 0, 0, 110);
        test_backpressure();
        test_phase('1, 79, 0, 110);
        test_phase(rnd48(), 0, 79, 110);
        test_phase(partner_pool[$urandom_range(2, POOL_SIZE - 1)], 16, 16, 110);
        settle();

        if (error_count == 0 && pending_captures.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
